>>> hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define CGRB_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("cgrb assertion failed");

// Consequent checked in the cycle after the antecedent.
`define CGRB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("cgrb assertion failed");

`endif

>>> hdl/cgrb_pkg.sv
package cgrb_pkg;

  localparam int MAX_ROWS    = 16;
  localparam int QMARK_CODE  = 63;
  localparam int STORE_SLOTS = 4096;
  localparam int Q_DEPTH     = 4;

  // input mode codes
  localparam logic [1:0] MODE_DRAW       = 2'd0;
  localparam logic [1:0] MODE_LOAD_GLYPH = 2'd1;
  localparam logic [1:0] MODE_LOAD_ADV   = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_DRAW_COLOR    = 3'd0;
  localparam logic [2:0] CFG_SWAP_BYTES    = 3'd1;
  localparam logic [2:0] CFG_BUFFER_WIDTH  = 3'd2;
  localparam logic [2:0] CFG_BUFFER_HEIGHT = 3'd3;
  localparam logic [2:0] CFG_CLIP_LEFT     = 3'd4;
  localparam logic [2:0] CFG_CLIP_TOP      = 3'd5;
  localparam logic [2:0] CFG_CLIP_WIDTH    = 3'd6;
  localparam logic [2:0] CFG_CLIP_HEIGHT   = 3'd7;

  typedef enum logic [1:0] {
    KIND_DRAW  = 2'd0,
    KIND_GLYPH = 2'd1,
    KIND_ADV   = 2'd2
  } item_kind_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_ROWS = 2'b10
  } back_state_t;

  typedef struct packed {
    logic [15:0]        draw_color;
    logic               swap_bytes;
    logic [12:0]        buffer_width;
    logic [12:0]        buffer_height;
    logic signed [15:0] clip_left;
    logic signed [15:0] clip_top;
    logic [12:0]        clip_width;
    logic [12:0]        clip_height;
  } cfg_t;

  typedef struct packed {
    item_kind_t         kind;
    logic [11:0]        load_index;
    logic [7:0]         load_value;
    logic [7:0]         glyph_idx;
    logic [7:0]         col_mask;
    logic signed [15:0] pos_y;
    logic [27:0]        pix_base;
  } q_item_t;

endpackage

>>> hdl/cgrb_ram.sv
module cgrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                        clk,
  input  logic                                        we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                            wdata,
  input  logic                                        re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                            rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> hdl/cgrb_front.sv
module cgrb_front #(
  parameter int FONT_FIRST = 32,
  parameter int FONT_LAST  = 126
) (
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_char_code,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [11:0]        in_load_index,
  input  logic [7:0]         in_load_value,
  input  cgrb_pkg::cfg_t     cfg,
  input  logic               q_full,
  output logic               q_push,
  output cgrb_pkg::q_item_t  q_item
);
  import cgrb_pkg::*;

  localparam bit QMARK_IN    = (QMARK_CODE >= FONT_FIRST) && (QMARK_CODE <= FONT_LAST);
  localparam int FALLBACK_GI = QMARK_IN ? (QMARK_CODE - FONT_FIRST) : 0;

  logic               is_item;
  logic               in_font;
  logic [7:0]         col_mask;
  logic signed [17:0] px_s;
  logic signed [17:0] x_s;
  logic signed [17:0] bw_s;
  logic signed [17:0] cl_s;
  logic signed [17:0] cr_s;
  logic signed [29:0] prod_s;
  logic signed [29:0] pix_s;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full && is_item;

  // column visibility, one lane per glyph column
  always_comb begin
    px_s = 18'(in_pos_x);
    bw_s = $signed({5'b0, cfg.buffer_width});
    cl_s = 18'(cfg.clip_left);
    cr_s = cl_s + $signed({5'b0, cfg.clip_width});
    x_s  = px_s;
    for (int c = 0; c < 8; c++) begin
      x_s = px_s + 18'(c);
      col_mask[c] = (x_s >= 0) && (x_s < bw_s) &&
                    ((cfg.clip_width == '0) || ((x_s >= cl_s) && (x_s < cr_s)));
    end
  end

  // pixel index of row 0, column 0
  always_comb begin
    prod_s = in_pos_y * $signed({1'b0, cfg.buffer_width});
    pix_s  = prod_s + 30'(in_pos_x);
  end

  assign in_font = (int'(in_char_code) >= FONT_FIRST) && (int'(in_char_code) <= FONT_LAST);

  always_comb begin
    is_item = 1'b1;
    q_item.kind = KIND_DRAW;
    case (in_mode)
      MODE_DRAW:       q_item.kind = KIND_DRAW;
      MODE_LOAD_GLYPH: q_item.kind = KIND_GLYPH;
      MODE_LOAD_ADV:   q_item.kind = KIND_ADV;
      default:         is_item = 1'b0;
    endcase
    q_item.load_index = in_load_index;
    q_item.load_value = in_load_value;
    q_item.glyph_idx  = in_font ? 8'(int'(in_char_code) - FONT_FIRST) : 8'(FALLBACK_GI);
    q_item.col_mask   = col_mask;
    q_item.pos_y      = in_pos_y;
    q_item.pix_base   = pix_s[27:0];
  end

endmodule

>>> hdl/cgrb_fifo.sv
module cgrb_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cgrb_pkg::q_item_t wr_item,
  output logic              full,
  input  logic              pop,
  output logic              valid,
  output cgrb_pkg::q_item_t rd_item
);
  import cgrb_pkg::*;

  localparam int PTR_W = $clog2(Q_DEPTH);

  q_item_t           slot_r [Q_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [PTR_W:0]    count_r, count_nxt;

  assign full    = (count_r == (PTR_W + 1)'(Q_DEPTH));
  assign valid   = (count_r != '0);
  assign rd_item = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

>>> hdl/cgrb_back.sv
module cgrb_back #(
  parameter int FONT_FIRST      = 32,
  parameter int FONT_LAST       = 126,
  parameter int FONT_HEIGHT     = 16,
  parameter int FONT_CELL_WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cgrb_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  cgrb_pkg::q_item_t  q_item,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_glyph_row,
  output logic signed [27:0] out_pixel_address,
  output logic [7:0]         out_pixel_mask,
  output logic [15:0]        out_pixel_color,
  output logic [3:0]         out_advance,
  output logic               out_last
);
  import cgrb_pkg::*;

  localparam int GLYPH_COUNT  = (FONT_LAST >= FONT_FIRST) ? (FONT_LAST - FONT_FIRST + 1) : 0;
  localparam int ROW_BYTES    = (FONT_CELL_WIDTH + 7) / 8;
  localparam int GLYPH_STRIDE = ROW_BYTES * FONT_HEIGHT;
  localparam int STORE_DEPTH  = GLYPH_STRIDE * GLYPH_COUNT;
  localparam int STORE_LIM    = (STORE_DEPTH < STORE_SLOTS) ? STORE_DEPTH : STORE_SLOTS;
  localparam int G_DEPTH      = (STORE_LIM > 0) ? STORE_LIM : 1;
  localparam int G_AW         = (G_DEPTH > 1) ? $clog2(G_DEPTH) : 1;
  localparam int SA_W         = ($clog2(STORE_DEPTH + 1) > 1) ? $clog2(STORE_DEPTH + 1) : 1;
  localparam int A_DEPTH      = (GLYPH_COUNT > 0) ? GLYPH_COUNT : 1;
  localparam int A_AW         = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
  localparam int NROWS        = (FONT_HEIGHT < MAX_ROWS) ? FONT_HEIGHT : MAX_ROWS;
  localparam logic [3:0] LAST_ROW = 4'(NROWS - 1);

  back_state_t        state_r, state_nxt;
  logic [3:0]         row_r;
  logic signed [17:0] y_r;
  logic [SA_W-1:0]    gaddr_r;
  logic [27:0]        paddr_r;
  logic [7:0]         colmask_r;

  logic               s1_valid_r;
  logic [3:0]         s1_row_r;
  logic [27:0]        s1_paddr_r;
  logic               s1_show_r;
  logic               s1_last_r;

  logic               out_free;
  logic               s1_free;
  logic               issue;
  logic               is_idle;
  logic               pop_draw;
  logic [3:0]         iss_row;
  logic signed [17:0] iss_y;
  logic [SA_W-1:0]    iss_gaddr;
  logic [SA_W-1:0]    head_base;
  logic [27:0]        iss_paddr;
  logic               iss_vis;
  logic               iss_inrng;
  logic signed [17:0] bh_s;
  logic signed [17:0] ct_s;
  logic signed [17:0] cb_s;
  logic [7:0]         adv_mask;
  logic [7:0]         g_rdata;
  logic [3:0]         a_rdata;
  logic               g_we;
  logic               a_we;

  assign out_free = !out_valid || out_ready;
  assign s1_free  = !s1_valid_r || out_free;
  assign is_idle  = (state_r == ST_IDLE);

  // sequencer: loads retire while idle, a draw issues one row per cycle while s1 is free
  always_comb begin
    state_nxt = state_r;
    q_pop     = 1'b0;
    issue     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.kind)
            KIND_DRAW: begin
              if (s1_free) begin
                q_pop = 1'b1;
                issue = 1'b1;
                if (LAST_ROW != 4'd0) begin
                  state_nxt = ST_ROWS;
                end
              end
            end
            default: q_pop = 1'b1;
          endcase
        end
      end
      ST_ROWS: begin
        if (s1_free) begin
          issue = 1'b1;
          if (row_r == LAST_ROW) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign pop_draw = q_pop && (q_item.kind == KIND_DRAW);
  assign g_we = q_pop && (q_item.kind == KIND_GLYPH) &&
                (13'(q_item.load_index) < 13'(STORE_LIM));
  assign a_we = q_pop && (q_item.kind == KIND_ADV) &&
                (13'(q_item.load_index) < 13'(GLYPH_COUNT));

  assign head_base = SA_W'(int'(q_item.glyph_idx) * GLYPH_STRIDE);
  assign iss_row   = is_idle ? 4'd0 : row_r;
  assign iss_y     = is_idle ? 18'(q_item.pos_y) : y_r;
  assign iss_gaddr = is_idle ? head_base : gaddr_r;
  assign iss_paddr = is_idle ? q_item.pix_base : paddr_r;

  // row visibility against buffer and optional clip band
  always_comb begin
    bh_s = $signed({5'b0, cfg.buffer_height});
    ct_s = 18'(cfg.clip_top);
    cb_s = ct_s + $signed({5'b0, cfg.clip_height});
    iss_vis = (iss_y >= 0) && (iss_y < bh_s) &&
              ((cfg.clip_height == '0) || ((iss_y >= ct_s) && (iss_y < cb_s)));
    iss_inrng = (iss_gaddr < SA_W'(STORE_LIM));
  end

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      adv_mask[c] = (4'(c) < a_rdata);
    end
  end

  cgrb_ram #(.WIDTH(8), .DEPTH(G_DEPTH)) u_glyph_ram (
    .clk   (clk),
    .we    (g_we),
    .waddr (q_item.load_index[G_AW-1:0]),
    .wdata (q_item.load_value),
    .re    (issue),
    .raddr (iss_gaddr[G_AW-1:0]),
    .rdata (g_rdata)
  );

  cgrb_ram #(.WIDTH(4), .DEPTH(A_DEPTH)) u_adv_ram (
    .clk   (clk),
    .we    (a_we),
    .waddr (q_item.load_index[A_AW-1:0]),
    .wdata (q_item.load_value[3:0]),
    .re    (pop_draw),
    .raddr (q_item.glyph_idx[A_AW-1:0]),
    .rdata (a_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      s1_valid_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (issue) begin
        s1_valid_r <= 1'b1;
      end else if (out_free) begin
        s1_valid_r <= 1'b0;
      end
      if (out_free) begin
        out_valid <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      row_r      <= iss_row + 4'd1;
      y_r        <= iss_y + 18'sd1;
      gaddr_r    <= iss_gaddr + SA_W'(ROW_BYTES);
      paddr_r    <= iss_paddr + 28'(cfg.buffer_width);
      s1_row_r   <= iss_row;
      s1_paddr_r <= iss_paddr;
      s1_show_r  <= iss_vis && iss_inrng;
      s1_last_r  <= (iss_row == LAST_ROW);
    end
    if (pop_draw) begin
      colmask_r <= q_item.col_mask;
    end
    if (out_free && s1_valid_r) begin
      out_glyph_row     <= s1_row_r;
      out_pixel_address <= $signed(s1_paddr_r);
      out_pixel_mask    <= s1_show_r ? (g_rdata & colmask_r & adv_mask) : 8'd0;
      out_pixel_color   <= cfg.swap_bytes ? {cfg.draw_color[7:0], cfg.draw_color[15:8]}
                                          : cfg.draw_color;
      out_advance       <= a_rdata;
      out_last          <= s1_last_r;
    end
  end

endmodule

>>> hdl/clipped_glyph_row_blitter_core.sv
// A draw goes through the queue, then each row through the glyph store read stage and
// the output register. A draw holds the row sequencer for min(FONT_HEIGHT,16) rows,
// one store read per row. Loads retire when idle; the 4-entry queue absorbs input bursts.
// Reset (rst_n low, synchronous): registers take their reset values, queue and row
// pipeline empty; glyph store and advance table keep their contents.
module clipped_glyph_row_blitter_core #(
  parameter int FONT_FIRST      = 32,
  parameter int FONT_LAST       = 126,
  parameter int FONT_HEIGHT     = 16,
  parameter int FONT_CELL_WIDTH = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  // configuration write channel
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data,
  // input item channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_mode,
  input  logic [7:0]         in_char_code,
  input  logic signed [15:0] in_pos_x,
  input  logic signed [15:0] in_pos_y,
  input  logic [11:0]        in_load_index,
  input  logic [7:0]         in_load_value,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_glyph_row,
  output logic signed [27:0] out_pixel_address,
  output logic [7:0]         out_pixel_mask,
  output logic [15:0]        out_pixel_color,
  output logic [3:0]         out_advance,
  output logic               out_last
);
  import cgrb_pkg::*;

  cfg_t    cfg_r, cfg_nxt;
  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_valid;
  q_item_t q_wr_item;
  q_item_t q_rd_item;

  // Writes go into cfg_r; the port never stalls. Values must only be
  // changed while no draw is in flight (not enforced); both halves read them directly.
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_DRAW_COLOR:    cfg_nxt.draw_color    = cfg_data;
        CFG_SWAP_BYTES:    cfg_nxt.swap_bytes    = cfg_data[0];
        CFG_BUFFER_WIDTH:  cfg_nxt.buffer_width  = cfg_data[12:0];
        CFG_BUFFER_HEIGHT: cfg_nxt.buffer_height = cfg_data[12:0];
        CFG_CLIP_LEFT:     cfg_nxt.clip_left     = $signed(cfg_data);
        CFG_CLIP_TOP:      cfg_nxt.clip_top      = $signed(cfg_data);
        CFG_CLIP_WIDTH:    cfg_nxt.clip_width    = cfg_data[12:0];
        CFG_CLIP_HEIGHT:   cfg_nxt.clip_height   = cfg_data[12:0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.draw_color    <= 16'hFFFF;
      cfg_r.swap_bytes    <= 1'b0;
      cfg_r.buffer_width  <= 13'd320;
      cfg_r.buffer_height <= 13'd240;
      cfg_r.clip_left     <= '0;
      cfg_r.clip_top      <= '0;
      cfg_r.clip_width    <= '0;
      cfg_r.clip_height   <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Front end: accepts beats, maps the code to a glyph (out-of-font codes
  // fall back to '?'), works out column clipping and the row 0 pixel index.
  // Mode 3 beats are taken and dropped here.
  cgrb_front #(
    .FONT_FIRST (FONT_FIRST),
    .FONT_LAST  (FONT_LAST)
  ) u_front (
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_char_code  (in_char_code),
    .in_pos_x      (in_pos_x),
    .in_pos_y      (in_pos_y),
    .in_load_index (in_load_index),
    .in_load_value (in_load_value),
    .cfg           (cfg_r),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_item        (q_wr_item)
  );

  // Loads travel through the same queue as draws, so a store write can
  // never overtake a draw still reading the glyph it replaces.
  cgrb_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .rd_item (q_rd_item)
  );

  // Back end: store writes, row sequencer, glyph store read stage and the
  // output register. Row clipping is decided per row as it issues.
  cgrb_back #(
    .FONT_FIRST      (FONT_FIRST),
    .FONT_LAST       (FONT_LAST),
    .FONT_HEIGHT     (FONT_HEIGHT),
    .FONT_CELL_WIDTH (FONT_CELL_WIDTH)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_item            (q_rd_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_glyph_row     (out_glyph_row),
    .out_pixel_address (out_pixel_address),
    .out_pixel_mask    (out_pixel_mask),
    .out_pixel_color   (out_pixel_color),
    .out_advance       (out_advance),
    .out_last          (out_last)
  );

endmodule

>>> hdl/cgrb_checker.sv
`include "assert_macros.svh"

module cgrb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               cfg_valid,
  input logic               cfg_ready,
  input logic [2:0]         cfg_index,
  input logic [15:0]        cfg_data,
  input logic               out_valid,
  input logic               out_ready,
  input logic [3:0]         out_glyph_row,
  input logic signed [27:0] out_pixel_address,
  input logic [7:0]         out_pixel_mask,
  input logic [15:0]        out_pixel_color,
  input logic [3:0]         out_advance,
  input logic               out_last
);
  import cgrb_pkg::*;

  logic [3:0]  exp_row_r;
  logic [27:0] prev_addr_r;
  logic [12:0] bw_r;
  logic        out_beat;

  assign out_beat = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_row_r <= '0;
      bw_r      <= 13'd320;
    end else begin
      if (out_beat) begin
        exp_row_r <= out_last ? 4'd0 : out_glyph_row + 4'd1;
      end
      if (cfg_valid && cfg_ready && (cfg_index == CFG_BUFFER_WIDTH)) begin
        bw_r <= cfg_data[12:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_beat) begin
      prev_addr_r <= out_pixel_address;
    end
  end

  `CGRB_ASSERT_NEXT(a_out_valid_holds, clk, rst_n, out_valid && !out_ready, out_valid)
  `CGRB_ASSERT_NEXT(a_out_payload_holds, clk, rst_n, out_valid && !out_ready, $stable(out_glyph_row) && $stable(out_pixel_address) && $stable(out_pixel_mask) && $stable(out_pixel_color) && $stable(out_advance) && $stable(out_last))
  `CGRB_ASSERT_SAME(a_rows_in_order, clk, rst_n, out_valid, out_glyph_row == exp_row_r)
  `CGRB_ASSERT_SAME(a_row_stride, clk, rst_n, out_valid && (exp_row_r != 4'd0), out_pixel_address == $signed(prev_addr_r + 28'(bw_r)))

endmodule

bind clipped_glyph_row_blitter_core cgrb_checker u_cgrb_checker (.*);

>>> bench/clipped_glyph_row_blitter_core_test.sv
`timescale 1ns / 1ps

module clipped_glyph_row_blitter_core_test;
  import cgrb_pkg::*;

  // Font geometry, matched to the instance parameters below.
  localparam int FONT_FIRST      = 32;
  localparam int FONT_LAST       = 126;
  localparam int FONT_HEIGHT     = 16;
  localparam int FONT_CELL_WIDTH = 8;
  localparam int GLYPH_COUNT     = FONT_LAST - FONT_FIRST + 1;
  localparam int ROW_BYTES       = (FONT_CELL_WIDTH + 7) / 8;
  localparam int GLYPH_BYTES     = ROW_BYTES * FONT_HEIGHT;
  localparam int STORE_DEPTH     = GLYPH_BYTES * GLYPH_COUNT;
  localparam int ROW_COUNT       = FONT_HEIGHT < MAX_ROWS ? FONT_HEIGHT : MAX_ROWS;

  // Mode code the block has no use for; it must produce nothing.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  localparam int     RANDOM_ITEMS = 9;       // per register setting, seven settings
  localparam int     TAIL_CYCLES  = 16;      // queue of four plus pipeline, with margin
  localparam longint CYCLE_LIMIT  = 500000;
  localparam int     PRINT_LIMIT  = 40;

  typedef struct {
    logic [1:0]         mode;
    logic [7:0]         char_code;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [11:0]        load_index;
    logic [7:0]         load_value;
  } blit_item_t;

  typedef struct {
    logic [3:0]         glyph_row;
    logic signed [27:0] pixel_address;
    logic [7:0]         pixel_mask;
    logic [15:0]        pixel_color;
    logic [3:0]         advance;
    logic               last;
  } row_beat_t;

  // Clock and reset
  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Block ports; every input starts at a known value
  logic               cfg_valid     = 1'b0;
  logic               cfg_ready;
  logic [2:0]         cfg_index     = CFG_DRAW_COLOR;
  logic [15:0]        cfg_data      = '0;
  logic               in_valid      = 1'b0;
  logic               in_ready;
  logic [1:0]         in_mode       = MODE_DRAW;
  logic [7:0]         in_char_code  = '0;
  logic signed [15:0] in_pos_x      = '0;
  logic signed [15:0] in_pos_y      = '0;
  logic [11:0]        in_load_index = '0;
  logic [7:0]         in_load_value = '0;
  logic               out_valid;
  logic               out_ready     = 1'b0;
  logic [3:0]         out_glyph_row;
  logic signed [27:0] out_pixel_address;
  logic [7:0]         out_pixel_mask;
  logic [15:0]        out_pixel_color;
  logic [3:0]         out_advance;
  logic               out_last;

  clipped_glyph_row_blitter_core #(
    .FONT_FIRST     (FONT_FIRST),
    .FONT_LAST      (FONT_LAST),
    .FONT_HEIGHT    (FONT_HEIGHT),
    .FONT_CELL_WIDTH(FONT_CELL_WIDTH)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_char_code     (in_char_code),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .in_load_index    (in_load_index),
    .in_load_value    (in_load_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_glyph_row    (out_glyph_row),
    .out_pixel_address(out_pixel_address),
    .out_pixel_mask   (out_pixel_mask),
    .out_pixel_color  (out_pixel_color),
    .out_advance      (out_advance),
    .out_last         (out_last)
  );

  // Predictor state: font contents and register shadow, updated as beats are accepted.
  logic [7:0] font_bytes [STORE_DEPTH];
  logic [3:0] font_adv   [GLYPH_COUNT];
  cfg_t       blit_cfg;

  // Stimulus side bookkeeping: which font entries the queued loads will have written.
  // Draws are only queued once their glyph is fully loaded.
  bit row_loaded [STORE_DEPTH];
  bit adv_loaded [GLYPH_COUNT];

  blit_item_t pending_items [$];   // items waiting for the input driver
  row_beat_t  pending_rows  [$];   // row beats predicted, not yet seen

  blit_item_t in_item;
  int     in_hold, in_calm, out_hold, out_calm;
  int     items_queued, items_taken, draws_taken, loads_taken;
  int     rows_checked, mismatch_count, settings_used;
  longint cycle_count;

  task automatic report_mismatch(input string what, input longint got, input longint want);
    mismatch_count++;
    if (mismatch_count <= PRINT_LIMIT)
      $display("mismatch, beat %0d: %s is %0h, expected %0h", rows_checked, what, got, want);
  endtask

  // Random idle count, with occasional runs of back-to-back beats.
  function automatic int pick_wait(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) begin
      calm = $urandom_range(8, 40);
      return 0;
    end
    return $urandom_range(0, 7);
  endfunction

  // Codes outside the font fall back to '?', or to glyph 0 if that is outside too.
  function automatic int glyph_of(input logic [7:0] code);
    if (int'(code) >= FONT_FIRST && int'(code) <= FONT_LAST)
      return int'(code) - FONT_FIRST;
    if (QMARK_CODE >= FONT_FIRST && QMARK_CODE <= FONT_LAST)
      return QMARK_CODE - FONT_FIRST;
    return 0;
  endfunction

  // Codes of the three glyphs loaded up front, or codes outside the font.
  function automatic logic [7:0] pick_code();
    case ($urandom_range(0, 4))
      0:       return $urandom_range(0, 1) ? 8'($urandom_range(0, FONT_FIRST - 1))
                                           : 8'($urandom_range(FONT_LAST + 1, 255));
      1:       return 8'(FONT_FIRST);
      2:       return 8'(FONT_LAST);
      default: return 8'(QMARK_CODE);
    endcase
  endfunction

  // Mostly widths that fit the cell, sometimes wider ones up to the 4-bit limit.
  function automatic int pick_width();
    return ($urandom_range(0, 3) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
  endfunction

  // Coordinate near the low or the high edge of interest, or anywhere in 16 bits.
  function automatic logic [15:0] pick_coord(input int near_lo, input int near_hi);
    case ($urandom_range(0, 4))
      0:       return 16'($urandom);
      1, 2:    return 16'(near_lo + int'($urandom_range(0, 24)) - 16);
      default: return 16'(near_hi + int'($urandom_range(0, 24)) - 16);
    endcase
  endfunction

  // Predictor: updates the font on loads, renders the row beats of a draw.
  task automatic apply_item(input blit_item_t it);
    int         gi, w, px, py, bw, bh, xs, xe, ys, ye, clip_lo, clip_hi;
    logic [7:0] colmask;
    logic [15:0] hue;
    longint     addr;
    row_beat_t  beat;
    case (it.mode)
      MODE_LOAD_GLYPH: begin
        loads_taken++;
        if (it.load_index < STORE_DEPTH) font_bytes[it.load_index] = it.load_value;
      end
      MODE_LOAD_ADV: begin
        loads_taken++;
        if (it.load_index < GLYPH_COUNT) font_adv[it.load_index] = it.load_value[3:0];
      end
      MODE_DRAW: begin
        draws_taken++;
        gi = glyph_of(it.char_code);
        w  = int'(font_adv[gi]);
        px = int'(it.pos_x);
        py = int'(it.pos_y);
        bw = int'(blit_cfg.buffer_width);
        bh = int'(blit_cfg.buffer_height);
        // visible column and row span within the glyph, buffer first
        xs = (px < 0) ? -px : 0;
        xe = (px + w > bw) ? bw - px : w;
        ys = (py < 0) ? -py : 0;
        ye = (py + FONT_HEIGHT > bh) ? bh - py : FONT_HEIGHT;
        // then the clip rectangle, per axis, when its size is non-zero
        if (blit_cfg.clip_width != 0) begin
          clip_lo = int'($signed(blit_cfg.clip_left));
          clip_hi = clip_lo + int'(blit_cfg.clip_width);
          if (px + xs < clip_lo) xs = clip_lo - px;
          if (px + xe > clip_hi) xe = clip_hi - px;
        end
        if (blit_cfg.clip_height != 0) begin
          clip_lo = int'($signed(blit_cfg.clip_top));
          clip_hi = clip_lo + int'(blit_cfg.clip_height);
          if (py + ys < clip_lo) ys = clip_lo - py;
          if (py + ye > clip_hi) ye = clip_hi - py;
        end
        // columns past 7 have no mask bit
        colmask = '0;
        for (int c = 0; c < 8; c++)
          if (c >= xs && c < xe) colmask[c] = 1'b1;
        hue = blit_cfg.swap_bytes ? {blit_cfg.draw_color[7:0], blit_cfg.draw_color[15:8]}
                                  : blit_cfg.draw_color;
        for (int r = 0; r < ROW_COUNT; r++) begin
          addr = longint'(py + r) * longint'(bw) + longint'(px);
          beat.glyph_row     = 4'(r);
          beat.pixel_address = addr[27:0];   // wraps at 28 bits
          beat.pixel_mask    = (r >= ys && r < ye)
                               ? font_bytes[gi * GLYPH_BYTES + r * ROW_BYTES] & colmask
                               : 8'h00;    // clipped rows still come out, empty
          beat.pixel_color   = hue;
          beat.advance       = font_adv[gi];
          beat.last          = (r == ROW_COUNT - 1);
          pending_rows.push_back(beat);
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_row_beat();
    row_beat_t want;
    rows_checked++;
    if (pending_rows.size() == 0) begin
      report_mismatch("row beat with none expected, pixel_address", out_pixel_address, 0);
      return;
    end
    want = pending_rows.pop_front();
    if (out_glyph_row !== want.glyph_row)
      report_mismatch("glyph_row", out_glyph_row, want.glyph_row);
    if (out_pixel_address !== want.pixel_address)
      report_mismatch("pixel_address", out_pixel_address, want.pixel_address);
    if (out_pixel_mask !== want.pixel_mask)
      report_mismatch("pixel_mask", out_pixel_mask, want.pixel_mask);
    if (out_pixel_color !== want.pixel_color)
      report_mismatch("pixel_color", out_pixel_color, want.pixel_color);
    if (out_advance !== want.advance)
      report_mismatch("advance", out_advance, want.advance);
    if (out_last !== want.last)
      report_mismatch("last", out_last, want.last);
  endtask

  // Input driver: pops the next item once the slot frees and the drawn gap has passed.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_hold = 0;
    end else begin
      if (in_valid && in_ready) begin
        apply_item(in_item);
        items_taken++;
        in_hold = pick_wait(in_calm);
      end
      if (!in_valid || in_ready) begin
        if (in_hold > 0) begin
          in_hold--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          in_item = pending_items.pop_front();
          in_valid      <= 1'b1;
          in_mode       <= in_item.mode;
          in_char_code  <= in_item.char_code;
          in_pos_x      <= in_item.pos_x;
          in_pos_y      <= in_item.pos_y;
          in_load_index <= in_item.load_index;
          in_load_value <= in_item.load_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: checks each accepted beat, then stalls a drawn number of cycles.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_hold = 0;
    end else begin
      if (out_valid && out_ready) begin
        check_row_beat();
        out_hold = pick_wait(out_calm);
      end
      if (out_hold > 0) begin
        out_hold--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d row beats outstanding",
               cycle_count, pending_rows.size());
      $display("status: fail");
      $finish;
    end
  end

  task automatic queue_item(input logic [1:0] mode, input logic [7:0] code,
                            input logic [15:0] x, input logic [15:0] y,
                            input logic [11:0] idx, input logic [7:0] val);
    blit_item_t it;
    it.mode       = mode;
    it.char_code  = code;
    it.pos_x      = x;
    it.pos_y      = y;
    it.load_index = idx;
    it.load_value = val;
    if (mode == MODE_LOAD_GLYPH && idx < STORE_DEPTH) row_loaded[idx] = 1'b1;
    if (mode == MODE_LOAD_ADV && idx < GLYPH_COUNT) adv_loaded[idx] = 1'b1;
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Full glyph: every row byte, then its width; unused fields carry noise.
  task automatic load_font_glyph(input int gi, input int width);
    logic [7:0] val;
    for (int r = 0; r < FONT_HEIGHT; r++) begin
      case ($urandom_range(0, 5))
        0:       val = 8'h00;
        1:       val = 8'hFF;
        default: val = 8'($urandom);
      endcase
      queue_item(MODE_LOAD_GLYPH, 8'($urandom), 16'($urandom), 16'($urandom),
                 12'(gi * GLYPH_BYTES + r * ROW_BYTES), val);
    end
    queue_item(MODE_LOAD_ADV, 8'($urandom), 16'($urandom), 16'($urandom),
               12'(gi), {4'($urandom), 4'(width)});
  endtask

  // Draw, preceded by a full glyph load when any entry it reads is still unwritten.
  task automatic queue_draw(input logic [7:0] code, input logic [15:0] x, input logic [15:0] y);
    int gi;
    bit whole;
    gi    = glyph_of(code);
    whole = adv_loaded[gi];
    for (int r = 0; r < FONT_HEIGHT; r++)
      if (!row_loaded[gi * GLYPH_BYTES + r * ROW_BYTES]) whole = 1'b0;
    if (!whole) load_font_glyph(gi, pick_width());
    queue_item(MODE_DRAW, code, x, y, 12'($urandom), 8'($urandom));
  endtask

  // Random mix: draws dominate, then font rewrites; ignored items do not count.
  task automatic queue_random_items(input int count);
    int         done, pick, clip_x, clip_y;
    bit         near_x, near_y;
    logic [7:0] code;
    done   = 0;
    clip_x = int'($signed(blit_cfg.clip_left));
    clip_y = int'($signed(blit_cfg.clip_top));
    while (done < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        code   = pick_code();
        near_x = blit_cfg.clip_width != 0 && $urandom_range(0, 1) == 1;
        near_y = blit_cfg.clip_height != 0 && $urandom_range(0, 1) == 1;
        queue_draw(code,
                   near_x ? pick_coord(clip_x, clip_x + int'(blit_cfg.clip_width))
                          : pick_coord(0, int'(blit_cfg.buffer_width)),
                   near_y ? pick_coord(clip_y, clip_y + int'(blit_cfg.clip_height))
                          : pick_coord(0, int'(blit_cfg.buffer_height)));
        done++;
      end else if (pick < 75) begin
        queue_item(MODE_LOAD_GLYPH, 8'($urandom), 16'($urandom), 16'($urandom),
                   12'($urandom_range(0, STORE_DEPTH - 1)), 8'($urandom));
        done++;
      end else if (pick < 85) begin
        queue_item(MODE_LOAD_ADV, 8'($urandom), 16'($urandom), 16'($urandom),
                   12'($urandom_range(0, GLYPH_COUNT - 1)), {4'($urandom), 4'(pick_width())});
        done++;
      end else if (pick < 93) begin
        // loads past the end of the store or table are dropped
        if ($urandom_range(0, 1))
          queue_item(MODE_LOAD_GLYPH, 8'($urandom), 16'($urandom), 16'($urandom),
                     12'($urandom_range(STORE_DEPTH, 4095)), 8'($urandom));
        else
          queue_item(MODE_LOAD_ADV, 8'($urandom), 16'($urandom), 16'($urandom),
                     12'($urandom_range(GLYPH_COUNT, 4095)), 8'($urandom));
      end else begin
        queue_item(MODE_SPARE, 8'($urandom), 16'($urandom), 16'($urandom),
                   12'($urandom), 8'($urandom));
      end
    end
  endtask

  // Everything accepted and every row beat seen, then let trailing loads retire.
  task automatic drain_phase();
    while (items_taken != items_queued || pending_rows.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_DRAW_COLOR:    blit_cfg.draw_color    = data;
      CFG_SWAP_BYTES:    blit_cfg.swap_bytes    = data[0];
      CFG_BUFFER_WIDTH:  blit_cfg.buffer_width  = data[12:0];
      CFG_BUFFER_HEIGHT: blit_cfg.buffer_height = data[12:0];
      CFG_CLIP_LEFT:     blit_cfg.clip_left     = data;
      CFG_CLIP_TOP:      blit_cfg.clip_top      = data;
      CFG_CLIP_WIDTH:    blit_cfg.clip_width    = data[12:0];
      CFG_CLIP_HEIGHT:   blit_cfg.clip_height   = data[12:0];
      default: ;
    endcase
  endtask

  // One register setting: write all eight (noise in unused upper data bits),
  // draw at the address extremes, then the random mix.
  task automatic run_phase(input logic [15:0] color, input logic swap,
                           input logic [12:0] bw, input logic [12:0] bh,
                           input logic [15:0] cl, input logic [15:0] ct,
                           input logic [12:0] cw, input logic [12:0] ch);
    write_reg(CFG_DRAW_COLOR,    color);
    write_reg(CFG_SWAP_BYTES,    {15'($urandom), swap});
    write_reg(CFG_BUFFER_WIDTH,  {3'($urandom), bw});
    write_reg(CFG_BUFFER_HEIGHT, {3'($urandom), bh});
    write_reg(CFG_CLIP_LEFT,     cl);
    write_reg(CFG_CLIP_TOP,      ct);
    write_reg(CFG_CLIP_WIDTH,    {3'($urandom), cw});
    write_reg(CFG_CLIP_HEIGHT,   {3'($urandom), ch});
    settings_used++;
    queue_draw(pick_code(), 16'h7FFF, 16'h7FFF);
    queue_draw(pick_code(), 16'h8000, 16'h8000);
    queue_random_items(RANDOM_ITEMS);
    drain_phase();
  endtask

  initial begin
    blit_cfg = '{draw_color: 16'hFFFF, swap_bytes: 1'b0,
                 buffer_width: 13'd320, buffer_height: 13'd240,
                 clip_left: 16'sd0, clip_top: 16'sd0,
                 clip_width: 13'd0, clip_height: 13'd0};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, at reset register values (320 x 240, no clip rectangle).
    // '?' full width, first glyph zero width, last glyph widest.
    load_font_glyph(QMARK_CODE - FONT_FIRST, 8);
    load_font_glyph(0, 0);
    load_font_glyph(GLYPH_COUNT - 1, 15);
    queue_draw(8'(QMARK_CODE), 16'd0, 16'd0);
    queue_draw(8'd0, 16'd5, 16'd5);                        // below the font -> '?'
    queue_draw(8'd255, 16'(-3), 16'(-5));                  // above it, top-left clipped
    queue_draw(8'(FONT_LAST + 1), 16'(-7), 16'd239);       // just past the font, bottom row
    queue_draw(8'(FONT_FIRST), 16'd316, 16'd230);
    queue_draw(8'(FONT_LAST), 16'd316, 16'd230);           // right and bottom edges
    queue_draw(8'(FONT_LAST), 16'd10, 16'd10);             // width beyond the mask
    // out of range loads must leave the font untouched
    queue_item(MODE_LOAD_GLYPH, 8'd0, 16'd0, 16'd0, 12'(STORE_DEPTH), 8'hFF);
    queue_item(MODE_LOAD_GLYPH, 8'd0, 16'd0, 16'd0, 12'hFFF, 8'hFF);
    queue_item(MODE_LOAD_ADV, 8'd0, 16'd0, 16'd0, 12'(GLYPH_COUNT), 8'hFF);
    queue_item(MODE_LOAD_ADV, 8'd0, 16'd0, 16'd0, 12'hFFF, 8'hFF);
    queue_item(MODE_SPARE, 8'hFF, 16'hFFFF, 16'hFFFF, 12'hFFF, 8'hFF);
    queue_draw(8'(QMARK_CODE), 16'(-8), 16'(-16));         // fully off the top-left
    queue_draw(8'(FONT_LAST), 16'h8000, 16'h8000);
    queue_draw(8'(FONT_LAST), 16'h7FFF, 16'h7FFF);
    queue_random_items(RANDOM_ITEMS);
    drain_phase();

    // 1 x 1 buffer, swapped colour
    run_phase(16'h1234, 1'b1, 13'd1, 13'd1, 16'h0000, 16'h0000, 13'd0, 13'd0);
    // small buffer with a tight clip window inside it
    run_phase(16'hF00F, 1'b1, 13'd40, 13'd24, 16'h0003, 16'h0002, 13'd5, 13'd9);
    // 4096 x 4096 buffer and clip, most negative clip origin; addresses wrap
    run_phase(16'h0000, 1'b0, 13'd4096, 13'd4096, 16'h8000, 16'h8000, 13'd4096, 13'd4096);
    // one-pixel clip at the far corner of coordinate space
    run_phase(16'h8001, 1'b1, 13'd320, 13'd240, 16'h7FFF, 16'h7FFF, 13'd1, 13'd1);
    // column clipping only, window starting left of the buffer
    run_phase(16'hFFFF, 1'b0, 13'd97, 13'd61, 16'hFFF9, 16'h0032, 13'd30, 13'd0);
    // row clipping only, narrow buffer
    run_phase(16'h5AA5, 1'b1, 13'd8, 13'd4096, 16'h0002, 16'hFFFC, 13'd0, 13'd7);

    if (pending_rows.size() != 0)
      report_mismatch("row beats left over at end, count", pending_rows.size(), 0);
    $display("covered %0d draws and %0d loads over %0d register settings plus reset values",
             draws_taken, loads_taken, settings_used);
    $display("checked %0d row beats, %0d mismatches", rows_checked, mismatch_count);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
